// ===== hw/rtl/lshs_pkg.sv =====
// Package with the shared types, codes and constants of the limit switch homing sequencer.
package lshs_pkg;

   // Configuration defaults and address decoding.
   localparam int ANGLE_BITS_DEFAULT = 32;
   localparam int CSR_ADDR_BITS      = 5;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [10:0] SEEK_SPEED_RESET          = 11'd100;
   localparam logic        SEEK_POSITIVE_RESET       = 1'b1;
   localparam logic [29:0] MIN_TRAVEL_RESET          = 30'd10000;
   localparam logic [31:0] HOME_POSITION_RESET       = 32'd0;
   localparam logic [29:0] RETRACT_DISTANCE_RESET    = 30'd5000;
   localparam logic        SWITCH_ACTIVE_LEVEL_RESET = 1'b0;

   // Register indexes, taken from paddr[4:2].
   localparam logic [2:0] REG_SEEK_SPEED          = 3'd0;
   localparam logic [2:0] REG_SEEK_POSITIVE       = 3'd1;
   localparam logic [2:0] REG_MIN_TRAVEL          = 3'd2;
   localparam logic [2:0] REG_HOME_POSITION       = 3'd3;
   localparam logic [2:0] REG_RETRACT_DISTANCE    = 3'd4;
   localparam logic [2:0] REG_SWITCH_ACTIVE_LEVEL = 3'd5;

   // Reciprocal of 5 scaled by 2^31, rounded up; exact for operands below 2^30.
   localparam int          RECIP5_SHIFT = 31;
   localparam logic [28:0] RECIP5       = 29'd429496730;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_POLL  = 2'd1,
      FUNC_DONE  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      CMD_NONE          = 3'd0,
      CMD_RUN           = 3'd1,
      CMD_MOVE_HOLD     = 3'd2,
      CMD_MOVE_COAST    = 3'd3,
      CMD_STOP          = 3'd4,
      CMD_SET_POSITION  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_BUSY         = 3'd0,
      ST_SUCCESS      = 3'd1,
      ST_CANCELED     = 3'd2,
      ST_SWITCH_ERROR = 3'd3,
      ST_MOTOR_FAULT  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SEEK  = 2'd1,
      PH_RETRY = 2'd2,
      PH_FINAL = 2'd3
   } phase_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [12:0] speed;
      logic [31:0] amount;
      status_type  status;
      logic        last;
   } res_type;

endpackage

// ===== hw/rtl/limit_switch_homing_sequencer_top.sv =====
// Top level of the limit switch homing sequencer: CSRs, event stage, result buffer.
//
//   channel  | direction | signals                       | content
//   req      | in        | tvalid tready tdata[39:0] tuser[1:0] | one event per transfer
//   rsp      | out       | tvalid tready tdata[47:0] tuser[2:0] tlast | one motor command each
//   csr      | in/out    | psel penable pwrite paddr[4:0] pwdata prdata pready | six registers
//
// An event is registered on accept and decided against the phase register once both
// result slots can take its results, which enter the output register as it is decided.
// Up to one event per cycle while rsp_tready is high; an event with two results holds
// the stage while the second result waits in the skid slot behind the output register.
// Reset is synchronous and returns the phase to idle with retries allowed.
// A stalled rsp side backs up into the event stage and then drops req_tready.
module limit_switch_homing_sequencer_top #(
   parameter int ANGLE_BITS = lshs_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: switch_level[0], angle[32:1], cancel[33], motor_fault[34], zero[39:35]
   input  logic [39:0]                        req_tdata,
   // tuser: func[1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: speed[12:0], amount[44:13], status[47:45]
   output logic [47:0]                        rsp_tdata,
   // tuser: command[2:0]
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lshs_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [lshs_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [lshs_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   // Angles are compared at no more than 32 bits.
   localparam int AW = (ANGLE_BITS < 32) ? ANGLE_BITS : 32;
   localparam int CW = (AW + 1 > 30) ? AW + 1 : 30;

   // Configuration registers.
   logic [10:0] seek_speed_ff;
   logic        seek_positive_ff;
   logic [29:0] min_travel_ff;
   logic [31:0] home_position_ff;
   logic [29:0] retract_distance_ff;
   logic        switch_active_level_ff;
   logic [30:0] retry_amt_ff;
   logic [30:0] retry_amt_in;

   // Event stage.
   logic          s1_valid_ff;
   logic [1:0]    s1_func_ff;
   logic          s1_sw_ff;
   logic [AW-1:0] s1_angle_ff;
   logic          s1_cancel_ff;
   logic          s1_fault_ff;
   logic          s1_fire;
   logic          req_fire;

   // Sequencer state.
   lshs_pkg::phase_type phase_ff;
   lshs_pkg::phase_type phase_in;
   logic                retry_allowed_ff;
   logic                retry_allowed_in;
   logic [AW-1:0]       start_angle_ff;
   logic [AW-1:0]       start_angle_in;

   // Output register and skid slot.
   lshs_pkg::res_type out_ff;
   logic              out_valid_ff;
   lshs_pkg::res_type sec_ff;
   logic              sec_valid_ff;

   // Decisions and results of the current event.
   logic              pressed;
   logic [AW:0]       diff;
   logic [AW:0]       travel;
   logic              travel_ok;
   logic [12:0]       fwd_speed;
   logic [12:0]       back_speed;
   logic [30:0]       retry_sum;
   logic [57:0]       retry_prod;
   logic [1:0]        n_results;
   lshs_pkg::res_type r0;
   lshs_pkg::res_type r1;
   logic              csr_write;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seek_speed_ff          <= lshs_pkg::SEEK_SPEED_RESET;
         seek_positive_ff       <= lshs_pkg::SEEK_POSITIVE_RESET;
         min_travel_ff          <= lshs_pkg::MIN_TRAVEL_RESET;
         home_position_ff       <= lshs_pkg::HOME_POSITION_RESET;
         retract_distance_ff    <= lshs_pkg::RETRACT_DISTANCE_RESET;
         switch_active_level_ff <= lshs_pkg::SWITCH_ACTIVE_LEVEL_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            lshs_pkg::REG_SEEK_SPEED:          seek_speed_ff          <= csr_pwdata[10:0];
            lshs_pkg::REG_SEEK_POSITIVE:       seek_positive_ff       <= csr_pwdata[0];
            lshs_pkg::REG_MIN_TRAVEL:          min_travel_ff          <= csr_pwdata[29:0];
            lshs_pkg::REG_HOME_POSITION:       home_position_ff       <= csr_pwdata;
            lshs_pkg::REG_RETRACT_DISTANCE:    retract_distance_ff    <= csr_pwdata[29:0];
            lshs_pkg::REG_SWITCH_ACTIVE_LEVEL: switch_active_level_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         lshs_pkg::REG_SEEK_SPEED:          csr_prdata = {21'd0, seek_speed_ff};
         lshs_pkg::REG_SEEK_POSITIVE:       csr_prdata = {31'd0, seek_positive_ff};
         lshs_pkg::REG_MIN_TRAVEL:          csr_prdata = {2'd0, min_travel_ff};
         lshs_pkg::REG_HOME_POSITION:       csr_prdata = home_position_ff;
         lshs_pkg::REG_RETRACT_DISTANCE:    csr_prdata = {2'd0, retract_distance_ff};
         lshs_pkg::REG_SWITCH_ACTIVE_LEVEL: csr_prdata = {31'd0, switch_active_level_ff};
         default:                           csr_prdata = '0;
      endcase
   end

   // Retry distance is the minimum travel m times 21/20 rounded half up, which equals
   // m + (m + 10) / 20; the divide by 5 is a reciprocal multiply.
   assign retry_sum    = {1'b0, min_travel_ff} + 31'd10;
   assign retry_prod   = retry_sum[30:2] * lshs_pkg::RECIP5;
   assign retry_amt_in = {1'b0, min_travel_ff}
                       + {4'd0, retry_prod[lshs_pkg::RECIP5_SHIFT +: 27]};

   always_ff @(posedge clock) begin
      retry_amt_ff <= retry_amt_in;
   end

   // ---------------------------------------------------------------- event stage
   // The stage may decide when both result slots will be free afterwards.
   assign s1_fire    = s1_valid_ff && (!out_valid_ff || (rsp_tready && !sec_valid_ff));
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff   <= req_tuser;
         s1_sw_ff     <= req_tdata[0];
         s1_angle_ff  <= req_tdata[AW:1];
         s1_cancel_ff <= req_tdata[33];
         s1_fault_ff  <= req_tdata[34];
      end
   end

   assign pressed    = (s1_sw_ff == switch_active_level_ff);
   assign diff       = {s1_angle_ff[AW-1], s1_angle_ff}
                     - {start_angle_ff[AW-1], start_angle_ff};
   assign travel     = diff[AW] ? ((AW+1)'(0) - diff) : diff;
   assign travel_ok  = CW'(travel) >= CW'(min_travel_ff);
   assign fwd_speed  = seek_positive_ff ? {2'b00, seek_speed_ff}
                                        : (13'd0 - {2'b00, seek_speed_ff});
   assign back_speed = 13'd0 - {fwd_speed[11:0], 1'b0};

   // Next state of the sequencer.
   always_comb begin
      phase_in         = phase_ff;
      retry_allowed_in = retry_allowed_ff;
      start_angle_in   = start_angle_ff;
      case (s1_func_ff)
         lshs_pkg::FUNC_START: begin
            start_angle_in   = s1_angle_ff;
            retry_allowed_in = 1'b1;
            phase_in         = s1_fault_ff ? lshs_pkg::PH_IDLE : lshs_pkg::PH_SEEK;
         end
         lshs_pkg::FUNC_POLL: begin
            if (phase_ff == lshs_pkg::PH_SEEK) begin
               if (pressed) begin
                  if (travel_ok) begin
                     phase_in = s1_fault_ff ? lshs_pkg::PH_IDLE : lshs_pkg::PH_FINAL;
                  end else if (!retry_allowed_ff) begin
                     phase_in = lshs_pkg::PH_IDLE;
                  end else begin
                     retry_allowed_in = 1'b0;
                     phase_in = s1_fault_ff ? lshs_pkg::PH_IDLE : lshs_pkg::PH_RETRY;
                  end
               end else if (s1_cancel_ff) begin
                  phase_in = lshs_pkg::PH_IDLE;
               end
            end
         end
         lshs_pkg::FUNC_DONE: begin
            if (phase_ff == lshs_pkg::PH_RETRY || phase_ff == lshs_pkg::PH_FINAL) begin
               if (s1_fault_ff || pressed || phase_ff == lshs_pkg::PH_FINAL) begin
                  phase_in = lshs_pkg::PH_IDLE;
               end else begin
                  start_angle_in = s1_angle_ff;
                  phase_in       = lshs_pkg::PH_SEEK;
               end
            end
         end
         default: ;
      endcase
   end

   // Results of the current event.
   always_comb begin
      n_results = 2'd0;
      r0        = '{cmd: lshs_pkg::CMD_NONE, speed: 13'd0, amount: 32'd0,
                    status: lshs_pkg::ST_BUSY, last: 1'b1};
      r1        = r0;
      case (s1_func_ff)
         lshs_pkg::FUNC_START: begin
            n_results = 2'd1;
            r0.cmd    = lshs_pkg::CMD_RUN;
            r0.speed  = fwd_speed;
            r0.status = s1_fault_ff ? lshs_pkg::ST_MOTOR_FAULT : lshs_pkg::ST_BUSY;
         end
         lshs_pkg::FUNC_POLL: begin
            if (phase_ff == lshs_pkg::PH_SEEK) begin
               if (pressed) begin
                  n_results = 2'd1;
                  if (travel_ok) begin
                     // Set the axis position first, then back off the switch.
                     n_results = 2'd2;
                     r0.cmd    = lshs_pkg::CMD_SET_POSITION;
                     r0.amount = home_position_ff;
                     r0.last   = 1'b0;
                     r1.cmd    = lshs_pkg::CMD_MOVE_COAST;
                     r1.speed  = back_speed;
                     r1.amount = {2'd0, retract_distance_ff};
                     r1.status = s1_fault_ff ? lshs_pkg::ST_MOTOR_FAULT : lshs_pkg::ST_BUSY;
                  end else if (!retry_allowed_ff) begin
                     r0.cmd    = lshs_pkg::CMD_STOP;
                     r0.status = lshs_pkg::ST_SWITCH_ERROR;
                  end else begin
                     r0.cmd    = lshs_pkg::CMD_MOVE_HOLD;
                     r0.speed  = back_speed;
                     r0.amount = {1'b0, retry_amt_ff};
                     r0.status = s1_fault_ff ? lshs_pkg::ST_MOTOR_FAULT : lshs_pkg::ST_BUSY;
                  end
               end else if (s1_cancel_ff) begin
                  n_results = 2'd1;
                  r0.cmd    = lshs_pkg::CMD_STOP;
                  r0.status = lshs_pkg::ST_CANCELED;
               end
            end
         end
         lshs_pkg::FUNC_DONE: begin
            if (phase_ff == lshs_pkg::PH_RETRY || phase_ff == lshs_pkg::PH_FINAL) begin
               n_results = 2'd1;
               if (s1_fault_ff) begin
                  r0.status = lshs_pkg::ST_MOTOR_FAULT;
               end else if (pressed) begin
                  r0.status = lshs_pkg::ST_SWITCH_ERROR;
               end else if (phase_ff == lshs_pkg::PH_FINAL) begin
                  r0.status = lshs_pkg::ST_SUCCESS;
               end else begin
                  r0.cmd   = lshs_pkg::CMD_RUN;
                  r0.speed = fwd_speed;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= lshs_pkg::PH_IDLE;
         retry_allowed_ff <= 1'b1;
         start_angle_ff   <= '0;
      end else if (s1_fire) begin
         phase_ff         <= phase_in;
         retry_allowed_ff <= retry_allowed_in;
         start_angle_ff   <= start_angle_in;
      end
   end

   // ---------------------------------------------------------------- result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= sec_valid_ff;
            sec_valid_ff <= 1'b0;
         end
         if (s1_fire && n_results != 2'd0) begin
            out_valid_ff <= 1'b1;
            sec_valid_ff <= (n_results == 2'd2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && n_results != 2'd0) begin
         out_ff <= r0;
         sec_ff <= r1;
      end else if (out_valid_ff && rsp_tready && sec_valid_ff) begin
         out_ff <= sec_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.cmd;
   assign rsp_tdata  = {out_ff.status, out_ff.amount, out_ff.speed};
   assign rsp_tlast  = out_ff.last;

`ifndef SYNTHESIS
   // The skid slot only ever holds a result behind a valid output register.
   assert property (@(posedge clock) disable iff (reset) sec_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a result while the output register is empty");

   // A result that is not the last of its event always has its follower queued.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> sec_valid_ff)
      else $error("non-final result shown without its follower queued");

   // The skid slot is filled only by an event that produced two results.
   assert property (@(posedge clock) disable iff (reset)
      $rose(sec_valid_ff) |-> $past(s1_fire) && $past(n_results) == 2'd2)
      else $error("skid slot filled without a two-result event");
`endif

endmodule

// ===== verif/limit_switch_homing_sequencer_top_tb.sv =====
// Self-checking testbench for the limit switch homing sequencer, with stream and APB drivers.
`timescale 1ns / 100ps

module limit_switch_homing_sequencer_top_tb;
   import lshs_pkg::*;

   localparam logic [1:0] FUNC_IGNORED    = 2'd3;
   localparam int         RUN_LIMIT       = 400000;
   localparam int         SETTLE_CYCLES   = 8;
   localparam int         ITEMS_PER_PHASE = 195;
   localparam int         RANDOM_PHASES   = 8;
   localparam longint     ANG_MAX         = 64'sd2147483647;
   localparam longint     ANG_MIN         = -ANG_MAX - 1;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [39:0]              req_tdata;
   logic [1:0]               req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [47:0]              rsp_tdata;
   logic [2:0]               rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Register copies and sequencer state of the predictor.
   logic [10:0]        cfg_speed;
   logic               cfg_positive;
   logic [29:0]        cfg_min;
   logic [31:0]        cfg_home;
   logic [29:0]        cfg_retract;
   logic               cfg_level;
   phase_type          seq_phase;
   logic               retry_ok;
   logic signed [31:0] start_ang;

   res_type expected_cmds[$];
   res_type seen_cmd;
   res_type want_cmd;
   int      errors = 0;
   int      cycles = 0;
   int      idle_pct;
   int      stall_pct;

   typedef struct {
      logic [1:0]  func;
      logic        sw;
      logic [31:0] ang;
      logic        cancel;
      logic        fault;
      bit          typed;
      int          n;
      res_type     r0;
      res_type     r1;
   } dir_row_type;

   dir_row_type dir_rows[$];

   limit_switch_homing_sequencer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic res_type cmd_res(input cmd_type c, input int spd, input logic [31:0] amt,
                                       input status_type s, input logic l);
      res_type r;
      r.cmd    = c;
      r.speed  = spd[12:0];
      r.amount = amt;
      r.status = s;
      r.last   = l;
      return r;
   endfunction

   // Angle at distance span from base, on whichever side stays in the 32-bit range.
   function automatic logic [31:0] offset_angle(input longint base, input longint span);
      longint a;
      a = ($urandom_range(0, 1) != 0) ? base + span : base - span;
      if (a > ANG_MAX) a = base - span;
      if (a < ANG_MIN) a = base + span;
      return a[31:0];
   endfunction

   task automatic homing_step(input logic [1:0] f, input logic sw, input logic [31:0] ang,
                              input logic cancel, input logic fault,
                              output int n, output res_type r0, output res_type r1);
      logic       pressed;
      int         fwd;
      int         back;
      longint     travel;
      status_type mv_status;
      pressed   = (sw == cfg_level);
      fwd       = cfg_positive ? int'(cfg_speed) : -int'(cfg_speed);
      back      = -2 * fwd;
      mv_status = fault ? ST_MOTOR_FAULT : ST_BUSY;
      n  = 0;
      r0 = '0;
      r1 = '0;
      if (f == FUNC_START) begin
         start_ang = ang;
         retry_ok  = 1'b1;
         seq_phase = fault ? PH_IDLE : PH_SEEK;
         n  = 1;
         r0 = cmd_res(CMD_RUN, fwd, 32'd0, mv_status, 1'b1);
      end else if (f == FUNC_POLL && seq_phase == PH_SEEK) begin
         if (pressed) begin
            travel = longint'($signed(ang)) - longint'(start_ang);
            if (travel < 0) travel = -travel;
            if (travel >= longint'(cfg_min)) begin
               n  = 2;
               r0 = cmd_res(CMD_SET_POSITION, 0, cfg_home, ST_BUSY, 1'b0);
               r1 = cmd_res(CMD_MOVE_COAST, back, 32'(cfg_retract), mv_status, 1'b1);
               seq_phase = fault ? PH_IDLE : PH_FINAL;
            end else if (!retry_ok) begin
               n  = 1;
               r0 = cmd_res(CMD_STOP, 0, 32'd0, ST_SWITCH_ERROR, 1'b1);
               seq_phase = PH_IDLE;
            end else begin
               // Back off by 21/20 of the minimum travel, rounded half up.
               n  = 1;
               r0 = cmd_res(CMD_MOVE_HOLD, back, 32'((longint'(cfg_min) * 21 + 10) / 20),
                            mv_status, 1'b1);
               retry_ok  = 1'b0;
               seq_phase = fault ? PH_IDLE : PH_RETRY;
            end
         end else if (cancel) begin
            n  = 1;
            r0 = cmd_res(CMD_STOP, 0, 32'd0, ST_CANCELED, 1'b1);
            seq_phase = PH_IDLE;
         end
      end else if (f == FUNC_DONE && (seq_phase == PH_RETRY || seq_phase == PH_FINAL)) begin
         n = 1;
         if (fault) begin
            r0 = cmd_res(CMD_NONE, 0, 32'd0, ST_MOTOR_FAULT, 1'b1);
            seq_phase = PH_IDLE;
         end else if (pressed) begin
            r0 = cmd_res(CMD_NONE, 0, 32'd0, ST_SWITCH_ERROR, 1'b1);
            seq_phase = PH_IDLE;
         end else if (seq_phase == PH_FINAL) begin
            r0 = cmd_res(CMD_NONE, 0, 32'd0, ST_SUCCESS, 1'b1);
            seq_phase = PH_IDLE;
         end else begin
            r0 = cmd_res(CMD_RUN, fwd, 32'd0, ST_BUSY, 1'b1);
            start_ang = ang;
            seq_phase = PH_SEEK;
         end
      end
   endtask

   task automatic add_row(input logic [1:0] f, input logic sw, input logic [31:0] ang,
                          input logic cancel, input logic fault, input bit typed, input int n,
                          input res_type r0, input res_type r1);
      dir_row_type row;
      row.func   = f;
      row.sw     = sw;
      row.ang    = ang;
      row.cancel = cancel;
      row.fault  = fault;
      row.typed  = typed;
      row.n      = n;
      row.r0     = r0;
      row.r1     = r1;
      dir_rows.push_back(row);
   endtask

   // Presents one event and runs the predictor at the edge where it is accepted.
   task automatic send_event(input logic [1:0] f, input logic sw, input logic [31:0] ang,
                             input logic cancel, input logic fault, output int n,
                             output res_type r0, output res_type r1, output bit counted);
      phase_type was;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, fault, cancel, ang, sw};
      req_tuser  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      was = seq_phase;
      homing_step(f, sw, ang, cancel, fault, n, r0, r1);
      counted = (n > 0) || (f == FUNC_POLL && was == PH_SEEK);
   endtask

   // Mostly well-formed homing sequences; the rest is noise and broken sequences.
   task automatic gen_event(output logic [1:0] f, output logic sw, output logic [31:0] ang,
                            output logic cancel, output logic fault);
      int     pick;
      int     k;
      longint span;
      pick   = int'($urandom_range(0, 99));
      fault  = ($urandom_range(0, 99) < 6);
      cancel = 1'($urandom_range(0, 1));
      sw     = 1'($urandom_range(0, 1));
      ang    = $urandom;
      f      = 2'($urandom_range(0, 3));
      if (seq_phase == PH_IDLE) begin
         if (pick < 80) f = FUNC_START;
      end else if (seq_phase == PH_SEEK) begin
         if (pick < 45) begin
            f      = FUNC_POLL;
            sw     = ~cfg_level;
            cancel = ($urandom_range(0, 99) < 4);
            ang    = offset_angle(start_ang, longint'($urandom_range(0, cfg_min + 1000)));
         end else if (pick < 82) begin
            f  = FUNC_POLL;
            sw = cfg_level;
            k  = int'($urandom_range(0, 9));
            case (k)
               0:       span = longint'(cfg_min);
               1:       span = (cfg_min == 0) ? 64'sd0 : longint'(cfg_min) - 1;
               2, 3, 4: span = longint'($urandom_range(0, cfg_min));
               default: span = longint'(cfg_min) + longint'($urandom_range(0, 100000));
            endcase
            if (k != 9) ang = offset_angle(start_ang, span);
         end else if (pick < 88) begin
            f = FUNC_START;
         end
      end else begin
         if (pick < 75) begin
            f   = FUNC_DONE;
            sw  = ~cfg_level;
            ang = offset_angle(start_ang, longint'($urandom_range(0, 2000000)));
         end else if (pick < 85) begin
            f  = FUNC_DONE;
            sw = cfg_level;
         end else if (pick < 90) begin
            f = FUNC_START;
         end
      end
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_SEEK_SPEED:          cfg_speed    = val[10:0];
         REG_SEEK_POSITIVE:       cfg_positive = val[0];
         REG_MIN_TRAVEL:          cfg_min      = val[29:0];
         REG_HOME_POSITION:       cfg_home     = val;
         REG_RETRACT_DISTANCE:    cfg_retract  = val[29:0];
         REG_SWITCH_ACTIVE_LEVEL: cfg_level    = val[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [10:0] spd, input logic pos, input logic [29:0] mn,
                                 input logic [31:0] home, input logic [29:0] ret,
                                 input logic lvl);
      write_reg(REG_SEEK_SPEED, 32'(spd));
      write_reg(REG_SEEK_POSITIVE, 32'(pos));
      write_reg(REG_MIN_TRAVEL, 32'(mn));
      write_reg(REG_HOME_POSITION, home);
      write_reg(REG_RETRACT_DISTANCE, 32'(ret));
      write_reg(REG_SWITCH_ACTIVE_LEVEL, 32'(lvl));
   endtask

   // Polls and done events may produce nothing, so allow the pipeline to empty too.
   task automatic settle;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_cmd.cmd    = cmd_type'(rsp_tuser);
         seen_cmd.speed  = rsp_tdata[12:0];
         seen_cmd.amount = rsp_tdata[44:13];
         seen_cmd.status = status_type'(rsp_tdata[47:45]);
         seen_cmd.last   = rsp_tlast;
         if (expected_cmds.size() == 0) begin
            errors++;
            $display("%0t: expected no command", $time);
            $display("%0t:   actual cmd %0d speed %0d amount %0d status %0d last %0d",
                     $time, seen_cmd.cmd, $signed(seen_cmd.speed), $signed(seen_cmd.amount),
                     seen_cmd.status, seen_cmd.last);
         end else begin
            want_cmd = expected_cmds.pop_front();
            if (seen_cmd !== want_cmd) begin
               errors++;
               $display("%0t: expected cmd %0d speed %0d amount %0d status %0d last %0d",
                        $time, want_cmd.cmd, $signed(want_cmd.speed),
                        $signed(want_cmd.amount), want_cmd.status, want_cmd.last);
               $display("%0t:   actual cmd %0d speed %0d amount %0d status %0d last %0d",
                        $time, seen_cmd.cmd, $signed(seen_cmd.speed),
                        $signed(seen_cmd.amount), seen_cmd.status, seen_cmd.last);
            end
         end
      end
   end

   initial begin
      int          n;
      int          p;
      int          items;
      bit          counted;
      res_type     r0;
      res_type     r1;
      logic [1:0]  f;
      logic        sw;
      logic        cancel;
      logic        fault;
      logic [31:0] ang;

      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_pct    = 0;
      stall_pct   = 0;

      cfg_speed    = SEEK_SPEED_RESET;
      cfg_positive = SEEK_POSITIVE_RESET;
      cfg_min      = MIN_TRAVEL_RESET;
      cfg_home     = HOME_POSITION_RESET;
      cfg_retract  = RETRACT_DISTANCE_RESET;
      cfg_level    = SWITCH_ACTIVE_LEVEL_RESET;
      seq_phase    = PH_IDLE;
      retry_ok     = 1'b1;
      start_ang    = '0;

      // Reset settings: the switch reads as pressed at level 0.
      add_row(FUNC_IGNORED, 1'b1, 32'd0, 1'b1, 1'b1, 1, 0, '0, '0);
      add_row(FUNC_POLL, 1'b0, 32'd0, 1'b0, 1'b0, 1, 0, '0, '0);
      add_row(FUNC_DONE, 1'b1, 32'd0, 1'b0, 1'b0, 1, 0, '0, '0);
      add_row(FUNC_START, 1'b1, 32'd0, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_RUN, 100, 32'd0, ST_BUSY, 1'b1), '0);
      add_row(FUNC_POLL, 1'b1, 32'd1234, 1'b0, 1'b0, 1, 0, '0, '0);
      // The switch wins over a cancel in the same poll; the hit is early.
      add_row(FUNC_POLL, 1'b0, 32'd5000, 1'b1, 1'b0, 1, 1,
              cmd_res(CMD_MOVE_HOLD, -200, 32'd10500, ST_BUSY, 1'b1), '0);
      add_row(FUNC_POLL, 1'b0, 32'd0, 1'b1, 1'b0, 1, 0, '0, '0);
      add_row(FUNC_DONE, 1'b1, 32'd3000, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_RUN, 100, 32'd0, ST_BUSY, 1'b1), '0);
      // Second early hit, one short of the minimum travel.
      add_row(FUNC_POLL, 1'b0, 32'd12999, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_STOP, 0, 32'd0, ST_SWITCH_ERROR, 1'b1), '0);
      add_row(FUNC_START, 1'b1, 32'h8000_0000, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_RUN, 100, 32'd0, ST_BUSY, 1'b1), '0);
      add_row(FUNC_POLL, 1'b0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1, 2,
              cmd_res(CMD_SET_POSITION, 0, 32'd0, ST_BUSY, 1'b0),
              cmd_res(CMD_MOVE_COAST, -200, 32'd5000, ST_BUSY, 1'b1));
      add_row(FUNC_DONE, 1'b1, 32'd0, 1'b0, 1'b1, 1, 1,
              cmd_res(CMD_NONE, 0, 32'd0, ST_MOTOR_FAULT, 1'b1), '0);
      add_row(FUNC_START, 1'b1, 32'd0, 1'b0, 1'b1, 1, 1,
              cmd_res(CMD_RUN, 100, 32'd0, ST_MOTOR_FAULT, 1'b1), '0);
      add_row(FUNC_START, 1'b1, 32'd100, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_RUN, 100, 32'd0, ST_BUSY, 1'b1), '0);
      add_row(FUNC_POLL, 1'b1, 32'd100, 1'b1, 1'b0, 1, 1,
              cmd_res(CMD_STOP, 0, 32'd0, ST_CANCELED, 1'b1), '0);
      add_row(FUNC_START, 1'b1, 32'd0, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_RUN, 100, 32'd0, ST_BUSY, 1'b1), '0);
      // Exactly the minimum travel in the negative direction, with a motor fault.
      add_row(FUNC_POLL, 1'b0, 32'hFFFF_D8F0, 1'b0, 1'b1, 1, 2,
              cmd_res(CMD_SET_POSITION, 0, 32'd0, ST_BUSY, 1'b0),
              cmd_res(CMD_MOVE_COAST, -200, 32'd5000, ST_MOTOR_FAULT, 1'b1));
      add_row(FUNC_START, 1'b1, 32'd7, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_RUN, 100, 32'd0, ST_BUSY, 1'b1), '0);
      add_row(FUNC_POLL, 1'b0, 32'd7, 1'b0, 1'b1, 1, 1,
              cmd_res(CMD_MOVE_HOLD, -200, 32'd10500, ST_MOTOR_FAULT, 1'b1), '0);
      add_row(FUNC_START, 1'b1, 32'd0, 1'b0, 1'b0, 0, 0, '0, '0);
      add_row(FUNC_START, 1'b1, 32'd50, 1'b0, 1'b0, 0, 0, '0, '0);
      add_row(FUNC_POLL, 1'b0, 32'd50, 1'b0, 1'b0, 0, 0, '0, '0);
      add_row(FUNC_DONE, 1'b0, 32'd50, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_NONE, 0, 32'd0, ST_SWITCH_ERROR, 1'b1), '0);
      add_row(FUNC_START, 1'b1, 32'd0, 1'b0, 1'b0, 0, 0, '0, '0);
      add_row(FUNC_POLL, 1'b0, 32'd5, 1'b0, 1'b0, 0, 0, '0, '0);
      add_row(FUNC_DONE, 1'b1, 32'hFFFF_FE0C, 1'b0, 1'b0, 0, 0, '0, '0);
      add_row(FUNC_POLL, 1'b0, 32'd20000, 1'b0, 1'b0, 0, 0, '0, '0);
      add_row(FUNC_DONE, 1'b1, 32'd0, 1'b0, 1'b0, 1, 1,
              cmd_res(CMD_NONE, 0, 32'd0, ST_SUCCESS, 1'b1), '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_event(dir_rows[i].func, dir_rows[i].sw, dir_rows[i].ang, dir_rows[i].cancel,
                    dir_rows[i].fault, n, r0, r1, counted);
         if (dir_rows[i].typed) begin
            n  = dir_rows[i].n;
            r0 = dir_rows[i].r0;
            r1 = dir_rows[i].r1;
         end
         if (n > 0) expected_cmds.push_back(r0);
         if (n > 1) expected_cmds.push_back(r1);
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            0: apply_settings(11'd0, 1'b0, 30'd0, 32'h8000_0000, 30'd0, 1'b1);
            1: apply_settings(11'd2000, 1'b1, 30'd1000000000, 32'h7FFF_FFFF, 30'd1000000000,
                              1'b0);
            default: apply_settings(11'($urandom_range(0, 2000)), 1'($urandom_range(0, 1)),
                                    ($urandom_range(0, 1) != 0)
                                       ? 30'($urandom_range(0, 50000))
                                       : 30'($urandom_range(0, 1000000000)),
                                    $urandom, 30'($urandom_range(0, 1000000000)),
                                    1'($urandom_range(0, 1)));
         endcase
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         items = 0;
         while (items < ITEMS_PER_PHASE) begin
            gen_event(f, sw, ang, cancel, fault);
            send_event(f, sw, ang, cancel, fault, n, r0, r1, counted);
            if (n > 0) expected_cmds.push_back(r0);
            if (n > 1) expected_cmds.push_back(r1);
            if (counted) items++;
         end
      end

      settle();
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
